/* hdl/edsd_pkg.sv */
// Shared constants, types and register codes for the ellipsoid distance pipeline.
package edsd_pkg;

  localparam int CW        = 24;
  localparam int REG_W     = 16;
  localparam int REG_COUNT = 6;
  localparam int IDX_W     = 3;

  localparam int U_W    = CW + REG_W;
  localparam int LO_W   = (U_W + 1) / 2;
  localparam int HI_W   = U_W - LO_W;
  localparam int ROOT_W = U_W + 1;
  localparam int SUM_W  = 2 * ROOT_W;
  localparam int R_W    = ROOT_W + 2;
  localparam int KLO_W  = (ROOT_W + 1) / 2;
  localparam int KHI_W  = ROOT_W - KLO_W;
  localparam int NUM_W  = 2 * ROOT_W + 1;
  localparam int DIV_SH = 14;
  localparam int FRAC_K = 26;
  localparam int D_W    = ROOT_W + DIV_SH;
  localparam int CMP_W  = ((NUM_W > D_W + CW) ? NUM_W : D_W + CW) + 1;

  localparam int FRONT_LAT = 4;
  localparam int PREP_LAT  = 4;
  localparam int LATENCY   = 1 + FRONT_LAT + ROOT_W + PREP_LAT + CW + 1;

  localparam logic [ROOT_W-1:0] K_ONE   = ROOT_W'(1) << FRAC_K;
  localparam logic [CW-1:0]     HALF    = CW'(1) << (CW - 1);
  localparam logic [CW-1:0]     HALF_M1 = HALF - CW'(1);

  typedef enum logic [IDX_W-1:0] {
    REG_INV_X    = 0,
    REG_INV_Y    = 1,
    REG_INV_Z    = 2,
    REG_INV_SQ_X = 3,
    REG_INV_SQ_Y = 4,
    REG_INV_SQ_Z = 5
  } reg_index_t;

  localparam logic [REG_W-1:0] REG_RESET [REG_COUNT] =
    '{16'd10923, 16'd5461, 16'd16384, 16'd7282, 16'd1820, 16'd16384};

  typedef struct packed {
    logic signed [CW-1:0] px;
    logic signed [CW-1:0] py;
    logic signed [CW-1:0] pz;
  } point_t;

  typedef struct packed {
    logic signed [CW-1:0] distance;
    logic                 at_centre;
  } result_t;

  typedef logic [2:0][CW-1:0]    mag_set_t;
  typedef logic [2:0][REG_W-1:0] axis_set_t;

  typedef struct packed {
    logic [SUM_W-1:0]  s;
    logic [R_W-1:0]    r;
    logic [ROOT_W-1:0] q;
  } root_word_t;

  typedef struct packed {
    logic [CMP_W-1:0] rem;
    logic [CMP_W-1:0] dsh;
    logic [CW-1:0]    q;
    logic             neg;
    logic             zero;
    logic             ovf;
  } div_word_t;

endpackage

/* hdl/edsd_front.sv */
// Scaled products, split squares and sums of squares for both scaled lengths.
module edsd_front (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  edsd_pkg::mag_set_t         mag,
  input  edsd_pkg::axis_set_t        inv,
  input  edsd_pkg::axis_set_t        inv_sq,
  output logic                       out_valid,
  output logic [edsd_pkg::SUM_W-1:0] sum_len,
  output logic [edsd_pkg::SUM_W-1:0] sum_sq
);

  logic [edsd_pkg::U_W-1:0]                     u      [2][3];
  logic [2*edsd_pkg::HI_W-1:0]                  pp_hh  [2][3];
  logic [edsd_pkg::HI_W+edsd_pkg::LO_W-1:0]     pp_hl  [2][3];
  logic [2*edsd_pkg::LO_W-1:0]                  pp_ll  [2][3];
  logic [edsd_pkg::SUM_W-1:0]                   sq     [2][3];
  logic [edsd_pkg::SUM_W-1:0]                   sq_next[2][3];
  logic [edsd_pkg::FRONT_LAT-1:0]               vld;

  always_comb begin
    for (int g = 0; g < 2; g++) begin
      for (int i = 0; i < 3; i++) begin
        sq_next[g][i] = (edsd_pkg::SUM_W'(pp_hh[g][i]) << (2 * edsd_pkg::LO_W))
                      + (edsd_pkg::SUM_W'(pp_hl[g][i]) << (edsd_pkg::LO_W + 1))
                      + edsd_pkg::SUM_W'(pp_ll[g][i]);
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      u[0][i] <= edsd_pkg::U_W'(mag[i]) * edsd_pkg::U_W'(inv[i]);
      u[1][i] <= edsd_pkg::U_W'(mag[i]) * edsd_pkg::U_W'(inv_sq[i]);
    end
    for (int g = 0; g < 2; g++) begin
      for (int i = 0; i < 3; i++) begin
        pp_hh[g][i] <= u[g][i][edsd_pkg::U_W-1:edsd_pkg::LO_W]
                     * u[g][i][edsd_pkg::U_W-1:edsd_pkg::LO_W];
        pp_hl[g][i] <= u[g][i][edsd_pkg::U_W-1:edsd_pkg::LO_W]
                     * u[g][i][edsd_pkg::LO_W-1:0];
        pp_ll[g][i] <= u[g][i][edsd_pkg::LO_W-1:0] * u[g][i][edsd_pkg::LO_W-1:0];
        sq[g][i]    <= sq_next[g][i];
      end
    end
    sum_len <= sq[0][0] + sq[0][1] + sq[0][2];
    sum_sq  <= sq[1][0] + sq[1][1] + sq[1][2];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[edsd_pkg::FRONT_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[edsd_pkg::FRONT_LAT-1];

endmodule

/* hdl/edsd_root_cell.sv */
// One digit step of the bit-pair square root, registered toward the next cell.
module edsd_root_cell (
  input  logic                   clk,
  input  edsd_pkg::root_word_t   word_in,
  output edsd_pkg::root_word_t   word_out
);

  logic [edsd_pkg::R_W-1:0] r2;
  logic [edsd_pkg::R_W-1:0] trial;
  logic                     take;

  always_comb begin
    r2    = {word_in.r[edsd_pkg::R_W-3:0],
             word_in.s[edsd_pkg::SUM_W-1:edsd_pkg::SUM_W-2]};
    trial = {word_in.q, 2'b01};
    take  = (r2 >= trial);
  end

  always_ff @(posedge clk) begin
    word_out.s <= word_in.s << 2;
    word_out.r <= take ? (r2 - trial) : r2;
    word_out.q <= {word_in.q[edsd_pkg::ROOT_W-2:0], take};
  end

endmodule

/* hdl/edsd_prep.sv */
// Turns the two scaled lengths into the rounded numerator, divisor and flags.
module edsd_prep (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic [edsd_pkg::ROOT_W-1:0] k0,
  input  logic [edsd_pkg::ROOT_W-1:0] k1,
  output logic                        out_valid,
  output edsd_pkg::div_word_t         word_out
);

  logic [edsd_pkg::ROOT_W-1:0]                 a1, dm1;
  logic [edsd_pkg::D_W-1:0]                    d1, d2, d3;
  logic                                        neg1, neg2, neg3, zero1, zero2, zero3;
  logic [2*edsd_pkg::KHI_W-1:0]                pp_hh;
  logic [edsd_pkg::KHI_W+edsd_pkg::KLO_W-1:0]  pp_hl, pp_lh;
  logic [2*edsd_pkg::KLO_W-1:0]                pp_ll;
  logic [edsd_pkg::NUM_W-1:0]                  num;
  logic [edsd_pkg::NUM_W-1:0]                  num_next;
  logic [edsd_pkg::PREP_LAT-1:0]               vld;

  always_comb begin
    num_next = (edsd_pkg::NUM_W'(pp_hh) << (2 * edsd_pkg::KLO_W))
             + ((edsd_pkg::NUM_W'(pp_hl) + edsd_pkg::NUM_W'(pp_lh)) << edsd_pkg::KLO_W)
             + edsd_pkg::NUM_W'(pp_ll)
             + edsd_pkg::NUM_W'(d2 >> 1);
  end

  always_ff @(posedge clk) begin
    // Distance to the unit level set and its sign.
    neg1  <= (k0 < edsd_pkg::K_ONE);
    dm1   <= (k0 < edsd_pkg::K_ONE) ? (edsd_pkg::K_ONE - k0) : (k0 - edsd_pkg::K_ONE);
    a1    <= k0;
    zero1 <= (k1 == '0);
    d1    <= edsd_pkg::D_W'(k1) << edsd_pkg::DIV_SH;
    // Partial products of the numerator.
    pp_hh <= a1[edsd_pkg::ROOT_W-1:edsd_pkg::KLO_W] * dm1[edsd_pkg::ROOT_W-1:edsd_pkg::KLO_W];
    pp_hl <= a1[edsd_pkg::ROOT_W-1:edsd_pkg::KLO_W] * dm1[edsd_pkg::KLO_W-1:0];
    pp_lh <= a1[edsd_pkg::KLO_W-1:0] * dm1[edsd_pkg::ROOT_W-1:edsd_pkg::KLO_W];
    pp_ll <= a1[edsd_pkg::KLO_W-1:0] * dm1[edsd_pkg::KLO_W-1:0];
    d2    <= d1;
    neg2  <= neg1;
    zero2 <= zero1;
    // Numerator with the rounding half of the divisor added in.
    num   <= num_next;
    d3    <= d2;
    neg3  <= neg2;
    zero3 <= zero2;
    // Quotients that need more than the output width saturate.
    word_out.rem  <= edsd_pkg::CMP_W'(num);
    word_out.dsh  <= edsd_pkg::CMP_W'(d3) << (edsd_pkg::CW - 1);
    word_out.q    <= '0;
    word_out.neg  <= neg3;
    word_out.zero <= zero3;
    word_out.ovf  <= (edsd_pkg::CMP_W'(num) >= (edsd_pkg::CMP_W'(d3) << edsd_pkg::CW));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[edsd_pkg::PREP_LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld[edsd_pkg::PREP_LAT-1];

endmodule

/* hdl/edsd_div_cell.sv */
// One quotient bit of the restoring division, registered toward the next cell.
module edsd_div_cell (
  input  logic                  clk,
  input  edsd_pkg::div_word_t   word_in,
  output edsd_pkg::div_word_t   word_out
);

  logic take;

  assign take = (word_in.rem >= word_in.dsh);

  always_ff @(posedge clk) begin
    word_out.rem  <= take ? (word_in.rem - word_in.dsh) : word_in.rem;
    word_out.dsh  <= word_in.dsh >> 1;
    word_out.q    <= {word_in.q[edsd_pkg::CW-2:0], take};
    word_out.neg  <= word_in.neg;
    word_out.zero <= word_in.zero;
    word_out.ovf  <= word_in.ovf;
  end

endmodule

/* hdl/ellipsoid_distance_3d.sv */
// Top level: ellipsoid signed distance bound, a pipeline of root and divider cells.
// Throughput is one word per cycle; the longest parts are 41 square-root cells and 24
// divider cells, each holding one word in flight. busy is high only during reset.
// Reset is synchronous and clears all valid flags and restores the six axis registers;
// the receiver cannot stall, each result word is shown with done for one cycle.
module ellipsoid_distance_3d (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  output logic                         busy,
  input  edsd_pkg::point_t             point,
  output logic                         done,
  output edsd_pkg::result_t            result,
  input  logic                         cfg_write,
  input  logic [edsd_pkg::IDX_W-1:0]   cfg_index,
  input  logic [edsd_pkg::REG_W-1:0]   cfg_data
);

  // Configuration registers, indexed by their register code.
  logic [edsd_pkg::REG_W-1:0] cfg_reg [edsd_pkg::REG_COUNT];

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_reg <= edsd_pkg::REG_RESET;
    end else if (cfg_write && (cfg_index < edsd_pkg::IDX_W'(edsd_pkg::REG_COUNT))) begin
      cfg_reg[cfg_index] <= cfg_data;
    end
  end

  edsd_pkg::axis_set_t inv, inv_sq;

  assign inv    = {cfg_reg[edsd_pkg::REG_INV_Z], cfg_reg[edsd_pkg::REG_INV_Y],
                   cfg_reg[edsd_pkg::REG_INV_X]};
  assign inv_sq = {cfg_reg[edsd_pkg::REG_INV_SQ_Z], cfg_reg[edsd_pkg::REG_INV_SQ_Y],
                   cfg_reg[edsd_pkg::REG_INV_SQ_X]};

  // The pipeline takes a word every cycle, so it only refuses words while in reset.
  assign busy = rst;

  // Input stage: coordinate magnitudes. The most negative value maps to 2^(CW-1).
  logic [edsd_pkg::CW-1:0] raw [3];
  edsd_pkg::mag_set_t      mag;
  edsd_pkg::mag_set_t      mag_next;
  logic                    in_vld;

  always_comb begin
    raw[0] = point.px;
    raw[1] = point.py;
    raw[2] = point.pz;
    for (int i = 0; i < 3; i++) begin
      mag_next[i] = raw[i][edsd_pkg::CW-1] ? (~raw[i] + 1'b1) : raw[i];
    end
  end

  always_ff @(posedge clk) begin
    mag <= mag_next;
    if (rst) begin
      in_vld <= 1'b0;
    end else begin
      in_vld <= start && !busy;
    end
  end

  // Scaled products and sums of squares for both lengths.
  logic                       front_vld;
  logic [edsd_pkg::SUM_W-1:0] sum_len, sum_sq;

  edsd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_vld),
    .mag      (mag),
    .inv      (inv),
    .inv_sq   (inv_sq),
    .out_valid(front_vld),
    .sum_len  (sum_len),
    .sum_sq   (sum_sq)
  );

  // Two rows of square-root cells, one result bit per cell; k0 and k1 leave the last cell.
  edsd_pkg::root_word_t        len_w [edsd_pkg::ROOT_W+1];
  edsd_pkg::root_word_t        sq_w  [edsd_pkg::ROOT_W+1];
  logic [edsd_pkg::ROOT_W:1]   root_vld;

  assign len_w[0] = '{s: sum_len, r: '0, q: '0};
  assign sq_w[0]  = '{s: sum_sq,  r: '0, q: '0};

  for (genvar j = 0; j < edsd_pkg::ROOT_W; j++) begin : g_root
    edsd_root_cell u_len_cell (.clk(clk), .word_in(len_w[j]), .word_out(len_w[j+1]));
    edsd_root_cell u_sq_cell  (.clk(clk), .word_in(sq_w[j]),  .word_out(sq_w[j+1]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      root_vld <= '0;
    end else begin
      root_vld <= {root_vld[edsd_pkg::ROOT_W-1:1], front_vld};
    end
  end

  // Numerator k0*|k0-1| plus half the divisor, divisor k1 shifted up, sign and flags.
  logic                prep_vld;
  edsd_pkg::div_word_t div_w [edsd_pkg::CW+1];
  logic [edsd_pkg::CW:1] div_vld;

  edsd_prep u_prep (
    .clk      (clk),
    .rst      (rst),
    .in_valid (root_vld[edsd_pkg::ROOT_W]),
    .k0       (len_w[edsd_pkg::ROOT_W].q),
    .k1       (sq_w[edsd_pkg::ROOT_W].q),
    .out_valid(prep_vld),
    .word_out (div_w[0])
  );

  // Row of divider cells, most significant quotient bit first.
  for (genvar j = 0; j < edsd_pkg::CW; j++) begin : g_div
    edsd_div_cell u_div_cell (.clk(clk), .word_in(div_w[j]), .word_out(div_w[j+1]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      div_vld <= '0;
    end else begin
      div_vld <= {div_vld[edsd_pkg::CW-1:1], prep_vld};
    end
  end

  // Output stage: saturate the magnitude, apply the sign, and handle the centre point.
  edsd_pkg::div_word_t     dv;
  logic [edsd_pkg::CW-1:0] lim, m;
  edsd_pkg::result_t       result_next;

  always_comb begin
    dv  = div_w[edsd_pkg::CW];
    lim = dv.neg ? edsd_pkg::HALF : edsd_pkg::HALF_M1;
    m   = (dv.ovf || (dv.q > lim)) ? lim : dv.q;
    if (dv.zero) begin
      result_next.distance  = '0;
      result_next.at_centre = 1'b1;
    end else begin
      result_next.distance  = (dv.neg && (m != '0)) ? (~m + 1'b1) : m;
      result_next.at_centre = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    result <= result_next;
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= div_vld[edsd_pkg::CW];
    end
  end

endmodule

/* hdl/edsd_checker.sv */
// Port-level checks for the ellipsoid distance block, bound to the top level.
module edsd_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input edsd_pkg::point_t           point,
  input logic                       done,
  input edsd_pkg::result_t          result
);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result word shown right after reset");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##(edsd_pkg::LATENCY) done)
    else $error("accepted word produced no result at the pipeline depth");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, edsd_pkg::LATENCY))
    else $error("result word without a matching accepted word");

  a_centre_zero: assert property (@(posedge clk) disable iff (rst)
    (done && result.at_centre) |-> (result.distance == '0))
    else $error("centre flag with nonzero distance");

  a_origin: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (point.px == '0) && (point.py == '0) && (point.pz == '0))
      |-> ##(edsd_pkg::LATENCY) (done && result.at_centre))
    else $error("origin point did not raise the centre flag");

endmodule

bind ellipsoid_distance_3d edsd_checker u_edsd_checker (.*);
